// ===== hw/rtl/hsv2rgb_pkg.sv =====
// shared types, constants and helpers for the hsv to rgb converter
package hsv2rgb_pkg;

  localparam logic [14:0] HUE_TURN    = 15'd23040;
  localparam logic [11:0] HUE_SECTOR  = 12'd3840;
  localparam logic [7:0]  FULL_SCALE  = 8'd255;
  // 255 * 3840, the ramp numerator at full weight
  localparam logic [19:0] RAMP_FULL   = 20'd979200;
  // ceil(2^32 / 3825), exact for quotients of 20-bit dividends
  localparam logic [20:0] RECIP_3825  = 21'd1122868;

  // hue sectors, 60 degrees each
  localparam logic [2:0] SEC_RED_YEL = 3'd0;
  localparam logic [2:0] SEC_YEL_GRN = 3'd1;
  localparam logic [2:0] SEC_GRN_CYN = 3'd2;
  localparam logic [2:0] SEC_CYN_BLU = 3'd3;
  localparam logic [2:0] SEC_BLU_MAG = 3'd4;
  localparam logic [2:0] SEC_MAG_RED = 3'd5;

  // after sector split
  typedef struct packed {
    logic [2:0]  sector;
    logic [11:0] ramp_gap;  // 3840 minus ramp weight
    logic [7:0]  sat;
    logic [7:0]  val;
  } sect_t;

  // after ramp numerator scaling
  typedef struct packed {
    logic [2:0]  sector;
    logic [19:0] ramp_num;  // v * num / 256, still to be divided by 3825
    logic [7:0]  low;
    logic [7:0]  val;
  } chan_t;

  // first hue of each sector
  function automatic logic [14:0] sector_base(input logic [2:0] sec);
    logic [14:0] base;
    case (sec)
      SEC_RED_YEL: base = 15'd0;
      SEC_YEL_GRN: base = 15'd3840;
      SEC_GRN_CYN: base = 15'd7680;
      SEC_CYN_BLU: base = 15'd11520;
      SEC_BLU_MAG: base = 15'd15360;
      default:     base = 15'd19200;
    endcase
    return base;
  endfunction

endpackage

// ===== hw/rtl/hsv2rgb_in_if.sv =====
// hsv pixel channel with valid/ready handshake
interface hsv2rgb_in_if;
  logic        valid;
  logic        ready;
  logic [14:0] hue;
  logic [7:0]  saturation;
  logic [7:0]  brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  output ready);
endinterface

// ===== hw/rtl/hsv2rgb_out_if.sv =====
// rgb pixel channel with valid/ready handshake
interface hsv2rgb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// ===== hw/rtl/hsv2rgb_sector.sv =====
// first stage: hue wrap, sector split and ramp weight
module hsv2rgb_sector (
  input  logic                clk,
  input  logic                rst_n,
  hsv2rgb_in_if.sink          in_ch,
  output logic                valid_out,
  output hsv2rgb_pkg::sect_t  data_out,
  input  logic                ready_down
);

  logic               valid_r;
  hsv2rgb_pkg::sect_t data_r;
  hsv2rgb_pkg::sect_t data_nxt;
  logic               ready_up;
  logic [14:0]        hue_w;
  logic [2:0]         sec;
  logic [14:0]        rem;

  assign ready_up    = !valid_r || ready_down;
  assign in_ch.ready = ready_up;

  always_comb begin
    // one full turn folds every 15-bit code into range
    hue_w = (in_ch.hue >= hsv2rgb_pkg::HUE_TURN) ? (in_ch.hue - hsv2rgb_pkg::HUE_TURN)
                                                 : in_ch.hue;
    sec = hsv2rgb_pkg::SEC_RED_YEL;
    for (int k = 1; k < 6; k++) begin
      if (hue_w >= hsv2rgb_pkg::sector_base(3'(k))) sec = 3'(k);
    end
    rem = hue_w - hsv2rgb_pkg::sector_base(sec);
    data_nxt.sector   = sec;
    // even sectors ramp up, odd ones down
    data_nxt.ramp_gap = sec[0] ? rem[11:0] : (hsv2rgb_pkg::HUE_SECTOR - rem[11:0]);
    data_nxt.sat      = in_ch.saturation;
    data_nxt.val      = in_ch.brightness;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_up) begin
      valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_up && in_ch.valid) begin
      data_r <= data_nxt;
    end
  end

  assign valid_out = valid_r;
  assign data_out  = data_r;

endmodule

// ===== hw/rtl/hsv2rgb_chroma.sv =====
// middle stages: chroma products, low channel and ramp numerator
module hsv2rgb_chroma (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                valid_in,
  input  hsv2rgb_pkg::sect_t  data_in,
  output logic                ready_up,
  output logic                valid_out,
  output hsv2rgb_pkg::chan_t  data_out,
  input  logic                ready_down
);

  // stage b: products
  logic        b_valid_r;
  logic [2:0]  b_sector_r;
  logic [19:0] b_sd_r;
  logic [15:0] b_lowprod_r;
  logic [7:0]  b_val_r;
  logic        b_rdy;

  // stage c: numerator and low channel
  logic        c_valid_r;
  logic [2:0]  c_sector_r;
  logic [19:0] c_num_r;
  logic [7:0]  c_low_r;
  logic [7:0]  c_val_r;
  logic        c_rdy;

  // stage d: scaled numerator
  logic        d_valid_r;
  logic [2:0]  d_sector_r;
  logic [19:0] d_y_r;
  logic [7:0]  d_low_r;
  logic [7:0]  d_val_r;
  logic        d_rdy;

  logic [19:0] sd_nxt;
  logic [15:0] lowprod_nxt;
  logic [15:0] low_sum;
  logic [7:0]  low_nxt;
  logic [19:0] num_nxt;
  logic [27:0] x_full;

  assign d_rdy    = !d_valid_r || ready_down;
  assign c_rdy    = !c_valid_r || d_rdy;
  assign b_rdy    = !b_valid_r || c_rdy;
  assign ready_up = b_rdy;

  assign sd_nxt      = {12'b0, data_in.sat} * {8'b0, data_in.ramp_gap};
  assign lowprod_nxt = {8'b0, data_in.val} * {8'b0, hsv2rgb_pkg::FULL_SCALE - data_in.sat};

  // floor(x / 255) for 16-bit x, with x at most 65025
  assign low_sum = b_lowprod_r + 16'd1 + {8'b0, b_lowprod_r[15:8]};
  assign low_nxt = low_sum[15:8];
  assign num_nxt = hsv2rgb_pkg::RAMP_FULL - b_sd_r;

  assign x_full = {20'b0, c_val_r} * {8'b0, c_num_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
      d_valid_r <= 1'b0;
    end else begin
      if (b_rdy) b_valid_r <= valid_in;
      if (c_rdy) c_valid_r <= b_valid_r;
      if (d_rdy) d_valid_r <= c_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_rdy && valid_in) begin
      b_sector_r  <= data_in.sector;
      b_sd_r      <= sd_nxt;
      b_lowprod_r <= lowprod_nxt;
      b_val_r     <= data_in.val;
    end
    if (c_rdy && b_valid_r) begin
      c_sector_r <= b_sector_r;
      c_num_r    <= num_nxt;
      c_low_r    <= low_nxt;
      c_val_r    <= b_val_r;
    end
    if (d_rdy && c_valid_r) begin
      d_sector_r <= c_sector_r;
      // dividing by 256 here leaves a division by 3825 for the last stage
      d_y_r      <= x_full[27:8];
      d_low_r    <= c_low_r;
      d_val_r    <= c_val_r;
    end
  end

  assign valid_out       = d_valid_r;
  assign data_out.sector = d_sector_r;
  assign data_out.ramp_num = d_y_r;
  assign data_out.low    = d_low_r;
  assign data_out.val    = d_val_r;

  // offset channel never exceeds brightness
  a_low_le_val: assert property (@(posedge clk) disable iff (!rst_n)
    c_valid_r |-> (c_low_r <= c_val_r))
    else $error("low channel above brightness");

  // ramp quotient must stay at or below brightness
  a_ramp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    d_valid_r |-> ({1'b0, d_y_r} < ({13'b0, d_val_r} + 21'd1) * 21'd3825))
    else $error("ramp numerator out of range");

  // a held item keeps its payload while the next stage is full
  a_hold_d: assert property (@(posedge clk) disable iff (!rst_n)
    (d_valid_r && !ready_down) |=> (d_valid_r && $stable(d_y_r) && $stable(d_low_r)))
    else $error("stalled stage changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!b_valid_r && !c_valid_r && !d_valid_r))
    else $error("pipeline not empty after reset");

endmodule

// ===== hw/rtl/hsv2rgb_place.sv =====
// last stage: ramp division by reciprocal and channel placement by sector
module hsv2rgb_place (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                valid_in,
  input  hsv2rgb_pkg::chan_t  data_in,
  output logic                ready_up,
  hsv2rgb_out_if.source       out_ch
);

  logic        valid_r;
  logic [7:0]  red_r;
  logic [7:0]  green_r;
  logic [7:0]  blue_r;
  logic [7:0]  red_nxt;
  logic [7:0]  green_nxt;
  logic [7:0]  blue_nxt;
  logic [40:0] prod;
  logic [7:0]  ramp;
  logic [7:0]  top;
  logic [7:0]  low;

  assign ready_up = !valid_r || out_ch.ready;

  assign prod = {21'b0, data_in.ramp_num} * {20'b0, hsv2rgb_pkg::RECIP_3825};
  assign ramp = prod[39:32];
  assign top  = data_in.val;
  assign low  = data_in.low;

  always_comb begin
    case (data_in.sector)
      hsv2rgb_pkg::SEC_RED_YEL: begin red_nxt = top;  green_nxt = ramp; blue_nxt = low;  end
      hsv2rgb_pkg::SEC_YEL_GRN: begin red_nxt = ramp; green_nxt = top;  blue_nxt = low;  end
      hsv2rgb_pkg::SEC_GRN_CYN: begin red_nxt = low;  green_nxt = top;  blue_nxt = ramp; end
      hsv2rgb_pkg::SEC_CYN_BLU: begin red_nxt = low;  green_nxt = ramp; blue_nxt = top;  end
      hsv2rgb_pkg::SEC_BLU_MAG: begin red_nxt = ramp; green_nxt = low;  blue_nxt = top;  end
      default:                  begin red_nxt = top;  green_nxt = low;  blue_nxt = ramp; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_up) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_up && valid_in) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign out_ch.valid = valid_r;
  assign out_ch.red   = red_r;
  assign out_ch.green = green_r;
  assign out_ch.blue  = blue_r;

endmodule

// ===== hw/rtl/hsv_to_rgb_converter.sv =====
// top level of the hsv to rgb pixel converter
// usage:
//   in_pix carries one hsv pixel per transaction: hue in degrees times 64
//   (codes of a full turn or more wrap once), saturation and brightness as
//   8-bit fractions. out_pix carries the matching 8-bit red, green, blue.
//   both channels move a transaction when valid and ready are high at a
//   rising clock edge.
// stages and throughput:
//   five register stages (sector split, products, low channel, ramp scaling,
//   reciprocal divide and placement). one pixel per cycle is sustained while
//   out_pix is ready; the products and the 20 by 21 bit reciprocal multiply
//   each sit in a stage of their own.
// reset:
//   synchronous active-low rst_n empties the pipeline; out_pix.valid is low
//   the cycle after.
// stalls:
//   each stage holds its transaction while the stage after it is full, so a
//   stall on out_pix fills the bubbles first and then drops in_pix.ready;
//   nothing is lost or repeated.
module hsv_to_rgb_converter (
  input  logic          clk,
  input  logic          rst_n,
  hsv2rgb_in_if.sink    in_pix,
  hsv2rgb_out_if.source out_pix
);

  logic               sect_valid;
  hsv2rgb_pkg::sect_t sect_data;
  logic               sect_ready;
  logic               chan_valid;
  hsv2rgb_pkg::chan_t chan_data;
  logic               chan_ready;

  hsv2rgb_sector u_sector (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_pix),
    .valid_out  (sect_valid),
    .data_out   (sect_data),
    .ready_down (sect_ready)
  );

  hsv2rgb_chroma u_chroma (
    .clk        (clk),
    .rst_n      (rst_n),
    .valid_in   (sect_valid),
    .data_in    (sect_data),
    .ready_up   (sect_ready),
    .valid_out  (chan_valid),
    .data_out   (chan_data),
    .ready_down (chan_ready)
  );

  hsv2rgb_place u_place (
    .clk      (clk),
    .rst_n    (rst_n),
    .valid_in (chan_valid),
    .data_in  (chan_data),
    .ready_up (chan_ready),
    .out_ch   (out_pix)
  );

endmodule
